FILE: hw/rtl/drls_pkg.sv
// Types and constants shared by the dropout run line slicer modules.
// Holds the item structs and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package drls_pkg;

	localparam int SPL_W   = 12;
	localparam int LPF_W   = 10;
	localparam int POS_W   = 24;
	localparam int DIV_W   = 23;
	localparam int STEP_W  = 5;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SPL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LPF = 1'b1;

	localparam logic [SPL_W-1:0] SPL_RESET = 12'd910;
	localparam logic [LPF_W-1:0] LPF_RESET = 10'd263;

	typedef struct packed {
		logic signed [31:0] frame_number;
		logic signed [23:0] run_start;
		logic signed [23:0] run_length;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] frame_tag;
		logic               field_select;
		logic [9:0]         field_line;
		logic [11:0]        start_col;
		logic [11:0]        end_col;
		logic               last_piece;
		logic               truncated;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic check;
		logic load;
	} drls_cmd_t;

	typedef struct packed {
		logic skip;
		logic keep_first;
		logic out_last;
	} drls_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/drls_dpath.sv
// Datapath of the dropout run line slicer: run capture, restoring divider,
// truncation check, piece walker and output item register. Uses drls_pkg.
`default_nettype none

module drls_dpath
	import drls_pkg::*;
#(
	parameter int MAX_PIECES = 64
) (
	input  wire logic               clk,
	input  wire in_item_t           in_item,
	input  wire logic [SPL_W-1:0]   spl,
	input  wire logic [LPF_W-1:0]   lpf,
	input  wire drls_cmd_t          cmd,
	output drls_status_t            status,
	output out_item_t               out_item
);

	localparam int CNT_W = $clog2(MAX_PIECES + 1);
	localparam int WIDE_W = POS_W + 1;

	logic signed [31:0] frame_q;
	logic [DIV_W-1:0]   start_q;
	logic [POS_W-1:0]   end_q;
	logic [DIV_W-1:0]   div_quo_q;
	logic [SPL_W-1:0]   div_rem_q;
	logic [POS_W-1:0]   line_q;
	logic [POS_W-1:0]   base_q;
	logic [SPL_W-1:0]   col_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               cut_q;
	out_item_t          out_q;

	logic [SPL_W:0]     rem_sh;
	logic               rem_ge;
	logic [POS_W-1:0]   base0;
	logic               cut_next;
	logic [WIDE_W-1:0]  line_end;
	logic [WIDE_W-1:0]  piece_end;
	logic               piece_last;

	assign rem_sh = {div_rem_q, div_quo_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, spl};

	assign base0 = POS_W'(start_q) - POS_W'(div_rem_q);
	assign cut_next = ((WIDE_W'(base0) + WIDE_W'(MAX_PIECES) * WIDE_W'(spl)) < WIDE_W'(end_q))
		&& (((WIDE_W'(div_quo_q) + WIDE_W'(MAX_PIECES)) >> 1) < WIDE_W'(lpf));

	assign line_end = WIDE_W'(base_q) + WIDE_W'(spl);
	assign piece_end = (WIDE_W'(end_q) < line_end) ? WIDE_W'(end_q) : line_end;
	assign piece_last = (WIDE_W'(end_q) <= line_end)
		|| (((WIDE_W'(line_q) + WIDE_W'(1)) >> 1) >= WIDE_W'(lpf))
		|| (cnt_q == CNT_W'(MAX_PIECES - 1));

	assign status.skip = in_item.run_length[23] || (in_item.run_length == '0)
		|| in_item.run_start[23] || (spl == '0);
	assign status.keep_first = (div_quo_q >> 1) < DIV_W'(lpf);
	assign status.out_last = out_q.last_piece;

	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q   <= in_item.frame_number;
			start_q   <= in_item.run_start[DIV_W-1:0];
			end_q     <= POS_W'(in_item.run_start[DIV_W-1:0])
				+ POS_W'(in_item.run_length[DIV_W-1:0]);
			div_quo_q <= in_item.run_start[DIV_W-1:0];
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				div_rem_q <= SPL_W'(rem_sh - {1'b0, spl});
			end else begin
				div_rem_q <= rem_sh[SPL_W-1:0];
			end
			div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
		end

		if (cmd.check) begin
			line_q <= POS_W'(div_quo_q);
			base_q <= base0;
			col_q  <= div_rem_q;
			cnt_q  <= '0;
			cut_q  <= cut_next;
		end else if (cmd.load) begin
			line_q <= line_q + POS_W'(1);
			base_q <= POS_W'(line_end);
			col_q  <= '0;
			cnt_q  <= cnt_q + CNT_W'(1);
		end

		if (cmd.load) begin
			out_q.frame_tag    <= frame_q;
			out_q.field_select <= line_q[0];
			out_q.field_line   <= 10'((line_q >> 1) + POS_W'(1));
			out_q.start_col    <= col_q;
			out_q.end_col      <= 12'(piece_end - WIDE_W'(base_q));
			out_q.last_piece   <= piece_last;
			out_q.truncated    <= cut_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/drls_ctrl.sv
// Controller of the dropout run line slicer: sequences capture, division,
// truncation check and piece emission. Uses drls_pkg.
`default_nettype none

module drls_ctrl
	import drls_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	input  wire drls_status_t status,
	output drls_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_LOAD,
		ST_SEND
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              stall_q;
	logic              valid_q;

	assign in_stall  = stall_q;
	assign out_valid = valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.check    = (state_q == ST_CHECK);
		cmd.load     = (state_q == ST_LOAD)
			|| ((state_q == ST_SEND) && !out_stall && !status.out_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			stall_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !status.skip) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						stall_q <= 1'b1;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_W - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status.keep_first) begin
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SEND;
					valid_q <= 1'b1;
				end
				ST_SEND: begin
					if (!out_stall && status.out_last) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b0;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dropout_run_line_slicer.sv
// A run is taken in ST_IDLE and then passes through ST_DIV, ST_CHECK and
// ST_LOAD; its first piece is valid once the controller reaches ST_SEND.
// Throughput: one piece per cycle while out_stall is low; the next run is
// taken the cycle after the last piece of the current one has gone out.
// A skipped run stays in ST_IDLE; a run with no field line ends in ST_CHECK.
// Reset clears control and loads the register defaults; there is no sweep.
`default_nettype none

module dropout_run_line_slicer
	import drls_pkg::*;
#(
	parameter int MAX_PIECES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [SPL_W-1:0] spl_q;
	logic [LPF_W-1:0] lpf_q;
	drls_cmd_t        cmd;
	drls_status_t     status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spl_q <= SPL_RESET;
			lpf_q <= LPF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPL: spl_q <= cfg_data[SPL_W-1:0];
				CFG_LPF: lpf_q <= cfg_data[LPF_W-1:0];
				default: ;
			endcase
		end
	end

	drls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	drls_dpath #(
		.MAX_PIECES (MAX_PIECES)
	) u_dpath (
		.clk      (clk),
		.in_item  (in_item),
		.spl      (spl_q),
		.lpf      (lpf_q),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

`ifndef ASSERT_OFF
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while pieces are pending");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_piece |=> out_valid)
		else $error("run ended without a last piece");

	a_next_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_piece |=> out_item.start_col == '0)
		else $error("follow-on piece does not start at column zero");

	a_trunc_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last_piece
		|=> out_item.truncated == $past(out_item.truncated))
		else $error("truncated flag changed within a run");
`endif

endmodule

`default_nettype wire
